>>> design/audio_decimate_vita_packetizer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the audio decimator and packetizer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef AUDIO_DECIMATE_VITA_PACKETIZER_MACROS_SVH
`define AUDIO_DECIMATE_VITA_PACKETIZER_MACROS_SVH
`ifndef SYNTHESIS
// Check that is suspended while reset is asserted.
`define ADVP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("advp assertion failed");
// Check that is also evaluated during reset.
`define ADVP_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("advp assertion failed");
`else
`define ADVP_ASSERT(name, clk, rst, prop)
`define ADVP_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

>>> design/advp_pkg.sv
// ---------------------------------------------------------------------------
// advp_pkg
// Shared constants and control types of the audio decimator and packetizer.
// ---------------------------------------------------------------------------
package advp_pkg;

   localparam int PAYLOAD_SAMPLES_DEFAULT = 128;
   localparam int MAX_RESULTS = 64;
   localparam int PAD_W = $clog2(MAX_RESULTS + 1);

   localparam int SAMPLE_W = 16;
   localparam int WORD_W = 32;
   localparam int GAIN_W = 16;
   localparam int SEQ_W = 4;
   localparam int CSR_IDX_W = 1;

   // Input operation codes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_ID = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 1'b1;

   localparam logic [WORD_W-1:0] STREAM_ID_RESET = 32'h8400_0000;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

   localparam logic [WORD_W-1:0] HDR_WORD0 = 32'h18d0_0047;
   localparam logic [WORD_W-1:0] HDR_CLASS0 = 32'h0000_1c2d;
   localparam logic [WORD_W-1:0] HDR_CLASS1 = 32'h534c_0123;
   localparam int HDR_WORDS = 7;
   localparam int HDR_CNT_W = $clog2(HDR_WORDS);

   localparam logic [SAMPLE_W-1:0] SAT_HI = 16'h7fff;
   localparam logic [SAMPLE_W-1:0] SAT_LO = 16'h8000;
   localparam int Q_SHIFT = 15;
   localparam logic [31:0] ROUND_HALF = 32'd16384;

   typedef struct packed {
      logic capture;
      logic round;
      logic hdr;
      logic data;
      logic pad;
   } advp_cmd_type;

   typedef struct packed {
      logic keep_phase;
      logic fill_zero;
      logic hdr_last;
      logic data_silent;
      logic pad_last;
      logic out_free;
   } advp_status_type;

endpackage

>>> design/audio_decimate_vita_packetizer.sv
// ---------------------------------------------------------------------------
// audio_decimate_vita_packetizer: 2:1 audio decimator with gain and packetizer
// A dropped sample flips the phase; a kept sample that opens a packet gets a header.
// Flush: up to 64 padding words, one per cycle while the output register is free.
// Stalls on the result side hold the sequencer, which handles one item at a time.
// Synchronous reset clears packet state and restores the register defaults.
// ---------------------------------------------------------------------------
`include "audio_decimate_vita_packetizer_macros.svh"

module audio_decimate_vita_packetizer import advp_pkg::*; #(
   parameter int PAYLOAD_SAMPLES = PAYLOAD_SAMPLES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [WORD_W-1:0]          csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [WORD_W-1:0]          rsp_word,
   output logic                       rsp_first,
   output logic                       rsp_last
);

   // The controller accepts an item only from its idle state. A kept sample
   // is multiplied in the accept cycle and rounded in the next one; after that
   // the header words for a new packet, and the payload word if a pair is complete
   // or the packet ends, go into the output register one per cycle while it is free.
   // Because the output register sits between the two sides, the block goes
   // back to idle and takes the next item while the last word still waits.
   advp_cmd_type    cmd;
   advp_status_type status;

   advp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration registers, the decimation phase,
   // the packet fill count, the pending half word and the sequence count.
   advp_datapath #(
      .PAYLOAD_SAMPLES (PAYLOAD_SAMPLES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_op     (req_op),
      .req_sample (req_sample),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .rsp_first  (rsp_first),
      .rsp_last   (rsp_last)
   );

   // A word is never loaded over one that is still waiting to be taken.
   `ADVP_ASSERT(a_no_overwrite, clock, reset, (cmd.hdr || cmd.pad) |-> (!rsp_valid || !rsp_stall))

   // The first word of a packet is a header word and never ends the packet.
   `ADVP_ASSERT(a_first_not_last, clock, reset, (rsp_valid && rsp_first) |-> !rsp_last)

   // While a packet's first header word is shown, the rest of the header is
   // still owed, so no new item can be taken.
   `ADVP_ASSERT(a_hdr_busy, clock, reset, (rsp_valid && rsp_first) |-> req_stall)

   // Reset empties the output register.
   `ADVP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

>>> design/advp_ctrl.sv
// ---------------------------------------------------------------------------
// advp_ctrl
// Sequencer that steps one item through scaling, header, payload or padding output.
// ---------------------------------------------------------------------------
module advp_ctrl import advp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_op,
   output logic            req_stall,
   input  advp_status_type status,
   output advp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_HDR   = 3'd2;
   localparam logic [2:0] S_DATA  = 3'd3;
   localparam logic [2:0] S_PAD   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_op == OP_FLUSH) begin
                  state_in = status.fill_zero ? S_IDLE : S_PAD;
               end else begin
                  state_in = status.keep_phase ? S_IDLE : S_ROUND;
               end
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in = status.fill_zero ? S_HDR : S_DATA;
         end
         S_HDR: begin
            if (status.out_free) begin
               cmd.hdr = 1'b1;
               if (status.hdr_last) begin
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (status.out_free || status.data_silent) begin
               cmd.data = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            if (status.out_free) begin
               cmd.pad = 1'b1;
               if (status.pad_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/advp_datapath.sv
// ---------------------------------------------------------------------------
// advp_datapath
// Gain multiply, rounding, packet state and the registered output word.
// ---------------------------------------------------------------------------
module advp_datapath import advp_pkg::*; #(
   parameter int PAYLOAD_SAMPLES = PAYLOAD_SAMPLES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [WORD_W-1:0]          csr_wdata,
   input  logic                       req_op,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  advp_cmd_type               cmd,
   output advp_status_type            status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [WORD_W-1:0]          rsp_word,
   output logic                       rsp_first,
   output logic                       rsp_last
);

   localparam int FILL_W = (PAYLOAD_SAMPLES > 2) ? $clog2(PAYLOAD_SAMPLES) : 1;
   localparam int PAYLOAD_WORDS = (PAYLOAD_SAMPLES + 1) / 2;
   localparam int REM_W = $clog2(PAYLOAD_WORDS + 1);

   localparam logic [HDR_CNT_W-1:0] HDR_IDX_WORD0 = 3'd0;
   localparam logic [HDR_CNT_W-1:0] HDR_IDX_STREAM = 3'd1;
   localparam logic [HDR_CNT_W-1:0] HDR_IDX_CLASS0 = 3'd2;
   localparam logic [HDR_CNT_W-1:0] HDR_IDX_CLASS1 = 3'd3;

   logic [WORD_W-1:0]   stream_id_ff, stream_id_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic                keep_phase_ff, keep_phase_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SAMPLE_W-1:0] pending_ff, pending_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [PAD_W-1:0]    pad_left_ff, pad_left_in;
   logic signed [32:0]  prod_ff, prod_in;
   logic [SAMPLE_W-1:0] scaled_ff, scaled_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_word_ff, rsp_word_in;
   logic                rsp_first_ff, rsp_first_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                fill_odd;
   logic                ends;
   logic                out_free;
   logic                data_silent;
   logic [REM_W-1:0]    rem_words;
   logic [PAD_W-1:0]    pad_calc;
   logic                neg;
   logic [32:0]         mag;
   logic [31:0]         mag_sum;
   logic [16:0]         mag_r;
   logic [16:0]         neg_r;
   logic [WORD_W-1:0]   hdr_word;

   assign fill_odd = fill_ff[0];
   assign ends = (fill_ff == FILL_W'(PAYLOAD_SAMPLES - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign data_silent = !fill_odd && !ends;

   // Words still owed by a flush, capped at the result limit.
   assign rem_words = REM_W'(PAYLOAD_WORDS) - REM_W'(fill_ff >> 1);
   assign pad_calc = (int'(rem_words) > MAX_RESULTS) ? PAD_W'(MAX_RESULTS)
                                                     : PAD_W'(rem_words);

   // Round half away from zero on the magnitude, then saturate.
   assign neg = prod_ff[32];
   assign mag = neg ? (-prod_ff) : prod_ff;
   assign mag_sum = mag[31:0] + ROUND_HALF;
   assign mag_r = mag_sum[31:Q_SHIFT];
   assign neg_r = -mag_r;

   always_comb begin
      case (hdr_cnt_ff)
         HDR_IDX_WORD0:  hdr_word = HDR_WORD0 | {12'd0, seq_ff, 16'd0};
         HDR_IDX_STREAM: hdr_word = stream_id_ff;
         HDR_IDX_CLASS0: hdr_word = HDR_CLASS0;
         HDR_IDX_CLASS1: hdr_word = HDR_CLASS1;
         default:        hdr_word = '0;
      endcase
   end

   always_comb begin
      stream_id_in = stream_id_ff;
      gain_in = gain_ff;
      keep_phase_in = keep_phase_ff;
      fill_in = fill_ff;
      pending_in = pending_ff;
      seq_in = seq_ff;
      hdr_cnt_in = hdr_cnt_ff;
      pad_left_in = pad_left_ff;
      prod_in = prod_ff;
      scaled_in = scaled_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in = rsp_word_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_STREAM_ID: stream_id_in = csr_wdata;
            CSR_GAIN:      gain_in = csr_wdata[GAIN_W-1:0];
            default:       stream_id_in = stream_id_ff;
         endcase
      end

      if (cmd.capture) begin
         prod_in = 33'(req_sample) * 33'($signed({1'b0, gain_ff}));
         hdr_cnt_in = '0;
         pad_left_in = pad_calc;
         if (req_op == OP_SAMPLE) begin
            keep_phase_in = !keep_phase_ff;
         end
      end

      if (cmd.round) begin
         if (!neg) begin
            scaled_in = (mag_r > 17'd32767) ? SAT_HI : mag_r[SAMPLE_W-1:0];
         end else begin
            scaled_in = (mag_r > 17'd32768) ? SAT_LO : neg_r[SAMPLE_W-1:0];
         end
      end

      if (cmd.hdr) begin
         rsp_valid_in = 1'b1;
         rsp_word_in = hdr_word;
         rsp_first_in = (hdr_cnt_ff == HDR_IDX_WORD0);
         rsp_last_in = 1'b0;
         hdr_cnt_in = hdr_cnt_ff + 1'b1;
      end

      if (cmd.data) begin
         if (data_silent) begin
            pending_in = scaled_ff;
            fill_in = fill_ff + 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_first_in = 1'b0;
            rsp_last_in = ends;
            rsp_word_in = fill_odd ? {pending_ff, scaled_ff} : {scaled_ff, 16'd0};
            if (ends) begin
               fill_in = '0;
               pending_in = '0;
               seq_in = seq_ff + 1'b1;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end

      if (cmd.pad) begin
         // An unpaired sample goes out with the first pad word only.
         rsp_valid_in = 1'b1;
         rsp_first_in = 1'b0;
         rsp_last_in = status.pad_last;
         rsp_word_in = fill_odd ? {pending_ff, 16'd0} : '0;
         pending_in = '0;
         pad_left_in = pad_left_ff - 1'b1;
         if (status.pad_last) begin
            fill_in = '0;
            seq_in = seq_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_id_ff <= STREAM_ID_RESET;
         gain_ff <= GAIN_RESET;
         keep_phase_ff <= 1'b0;
         fill_ff <= '0;
         pending_ff <= '0;
         seq_ff <= '0;
         hdr_cnt_ff <= '0;
         pad_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stream_id_ff <= stream_id_in;
         gain_ff <= gain_in;
         keep_phase_ff <= keep_phase_in;
         fill_ff <= fill_in;
         pending_ff <= pending_in;
         seq_ff <= seq_in;
         hdr_cnt_ff <= hdr_cnt_in;
         pad_left_ff <= pad_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff <= prod_in;
      scaled_ff <= scaled_in;
      rsp_word_ff <= rsp_word_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.keep_phase = keep_phase_ff;
   assign status.fill_zero = (fill_ff == '0);
   assign status.hdr_last = (hdr_cnt_ff == HDR_CNT_W'(HDR_WORDS - 1));
   assign status.data_silent = data_silent;
   assign status.pad_last = (pad_left_ff == PAD_W'(1));
   assign status.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;
   assign rsp_first = rsp_first_ff;
   assign rsp_last = rsp_last_ff;

endmodule
